FILE: sv/cse_pkg.sv
// cse_pkg: shared constants, types and the byte update function for the crc-32c engine
`default_nettype none

package cse_pkg;

    // item geometry
    localparam int unsigned BYTES_PER_ITEM = 8;
    localparam int unsigned DATA_W         = 8 * BYTES_PER_ITEM;
    localparam int unsigned COUNT_W        = 4;
    localparam int unsigned CRC_W          = 32;

    // apb register map
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_SEED   = 1'b0;

    // reflected castagnoli polynomial and all-ones mask
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

    typedef logic [CRC_W-1:0]   t_crc;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [COUNT_W-1:0] t_count;

    // configuration seen by the datapath
    typedef struct packed {
        t_crc seed_value;
    } t_cse_cfg;

    // one byte through the reflected crc, lsb first
    function automatic t_crc crc_byte(input t_crc rem_in, input logic [7:0] byte_in);
        t_crc r;
        r = rem_in ^ {24'd0, byte_in};
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cse_if.sv
// cse_in_if and cse_out_if: valid/ready channels for message items and crc results
`default_nettype none

interface cse_in_if;
    logic                    valid;
    logic                    ready;
    logic [cse_pkg::DATA_W-1:0]  data_word;
    logic [cse_pkg::COUNT_W-1:0] byte_count;
    logic                    first_item;
    logic                    last_item;

    modport source (output valid, output data_word, output byte_count,
                    output first_item, output last_item, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input first_item, input last_item, output ready);
endinterface

interface cse_out_if;
    logic                      valid;
    logic                      ready;
    logic [cse_pkg::CRC_W-1:0] crc_result;

    modport source (output valid, output crc_result, input ready);
    modport sink   (input valid, input crc_result, output ready);
endinterface

`default_nettype wire

FILE: sv/cse_apb_regs.sv
// cse_apb_regs: apb configuration register holding the crc seed
`default_nettype none

module cse_apb_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cse_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [cse_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [cse_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output cse_pkg::t_cse_cfg                      o_cfg
);
    import cse_pkg::*;

    t_crc r_seed;
    logic wr_en;
    logic reg_sel;

    // register index is the word address
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (wr_en && (reg_sel == REG_SEED)) begin
            r_seed <= pwdata[CRC_W-1:0];
        end
    end

    // read back
    always_comb begin
        unique case (reg_sel)
            REG_SEED: prdata = r_seed;
            default:  prdata = '0;
        endcase
    end

    assign o_cfg.seed_value = r_seed;

endmodule

`default_nettype wire

FILE: sv/cse_crc_pipe.sv
// cse_crc_pipe: input register, eight-byte crc update network and result register
`default_nettype none

module cse_crc_pipe (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cse_pkg::t_cse_cfg i_cfg,
    cse_in_if.sink                 i_in,
    cse_out_if.source              o_out
);
    import cse_pkg::*;

    // input stage
    logic   r_s1_valid;
    t_data  r_s1_data;
    t_count r_s1_count;
    logic   r_s1_first;
    logic   r_s1_last;

    // running remainder and result register
    t_crc   r_rem;
    t_crc   n_rem;
    logic   r_out_valid;
    t_crc   r_crc;

    logic   out_free;
    logic   s1_go;
    logic   in_take;

    // handshake: a non-last item never waits on the output side
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_go    = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_take  = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data  <= i_in.data_word;
            r_s1_count <= i_in.byte_count;
            r_s1_first <= i_in.first_item;
            r_s1_last  <= i_in.last_item;
        end
    end

    // byte update network, counts above eight take all eight bytes
    always_comb begin
        t_crc r;
        r = r_s1_first ? (i_cfg.seed_value ^ CRC_ALL_ONES) : r_rem;
        for (int k = 0; k < BYTES_PER_ITEM; k++) begin
            if (COUNT_W'(k) < r_s1_count) begin
                r = crc_byte(r, r_s1_data[8*k +: 8]);
            end
        end
        n_rem = r;
    end

    // remainder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= CRC_ALL_ONES;
        end else if (s1_go) begin
            r_rem <= n_rem;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_crc <= n_rem ^ CRC_ALL_ONES;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.crc_result = r_crc;

    // a fresh result only comes from a last item leaving the input stage
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_s1_valid && r_s1_last))
        else $error("result appeared without a last item");

    // a blocked input stage must hold off the next transaction
    a_block_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |-> !i_in.ready)
        else $error("input accepted while stage is blocked");

    // remainder only moves when an item is processed
    a_rem_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(s1_go)) |-> $stable(r_rem))
        else $error("remainder changed without an item");

    // a blocked last item means the result register is occupied and stalled
    a_last_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && !s1_go) |-> (r_out_valid && !o_out.ready))
        else $error("last item stalled with free result register");

endmodule

`default_nettype wire

FILE: sv/crc32c_stream_engine.sv
// crc32c_stream_engine: top level of the streaming crc-32c engine
// path: an accepted item is first registered in the input register; a last item's result
//   is then registered in the result register and is held there until it is accepted
// throughput: one item of up to eight bytes per cycle through the eight-byte xor
//   network; a last item waits only while the previous result is held unaccepted
// reset: synchronous active low; remainder all ones, seed zero, both stages empty
`default_nettype none

module crc32c_stream_engine (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    cse_in_if.sink                              i_in,
    cse_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cse_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cse_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cse_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import cse_pkg::*;

    t_cse_cfg cfg;

    // configuration registers
    cse_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // crc datapath
    cse_crc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
